// ----- src/uvc_pkg.sv -----
// Shared types, constants and character tables for the URI validator.
package uvc_pkg;

  localparam int unsigned CountWidthDef = 17;
  localparam int unsigned FifoDepthDef  = 2;
  localparam logic [15:0] MaxUriReset   = 16'd2048;
  localparam logic [2:0]  PrefixSat     = 3'd6;

  typedef enum logic [2:0] {
    FAULT_OK        = 3'd0,
    FAULT_SCHEME    = 3'd1,
    FAULT_NO_DEST   = 3'd2,
    FAULT_TOO_LONG  = 3'd3,
    FAULT_NEEDS_PCT = 3'd4
  } fault_e;

  typedef enum logic [1:0] {
    PCT_IDLE  = 2'd0,
    PCT_HEX1  = 2'd1,
    PCT_HEX2  = 2'd2
  } pct_phase_e;

  // One classified byte, as it travels from the front to the back.
  typedef struct packed {
    logic       term;
    logic       pct;
    logic       hex;
    logic       legal;
    logic [7:0] low;
  } byte_class_t;

  function automatic logic is_hex(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_unreserved(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2d || b == 8'h2e ||
           b == 8'h5f || b == 8'h7e;
  endfunction

  function automatic logic is_reserved(logic [7:0] b);
    logic r;
    unique case (b)
      8'h3a, 8'h2f, 8'h3f, 8'h23, 8'h5b, 8'h5d, 8'h40, 8'h21, 8'h24,
      8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Scheme index: 0 http:, 1 https:, 2 ftp:
  function automatic logic [2:0] scheme_len(logic [1:0] k);
    logic [2:0] n;
    unique case (k)
      2'd0:    n = 3'd5;
      2'd1:    n = 3'd6;
      2'd2:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] scheme_char(logic [1:0] k, logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      2'd0, 2'd1: begin
        unique case (pos)
          3'd0:       c = 8'h68;                          // h
          3'd1, 3'd2: c = 8'h74;                          // t
          3'd3:       c = 8'h70;                          // p
          3'd4:       c = (k == 2'd0) ? 8'h3a : 8'h73;    // : or s
          3'd5:       c = 8'h3a;
          default:    c = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (pos)
          3'd0:    c = 8'h66;                             // f
          3'd1:    c = 8'h74;
          3'd2:    c = 8'h70;
          3'd3:    c = 8'h3a;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/uvc_front.sv -----
// Front end: takes request bytes and classifies each one for the queue.
module uvc_front import uvc_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  uri_byte_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output byte_class_t cls_o
);

  logic [7:0] b;

  assign b          = uri_byte_i;
  assign in_ready_o = ~queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  always_comb begin
    cls_o.term  = (b == 8'h00);
    cls_o.pct   = (b == 8'h25);
    cls_o.hex   = is_hex(b);
    cls_o.legal = ~b[7] & (is_unreserved(b) | is_reserved(b));
    // fold upper case so the scheme compare sees one form
    cls_o.low   = (b >= 8'h41 && b <= 8'h5a) ? (b + 8'h20) : b;
  end

endmodule

// ----- src/uvc_fifo.sv -----
// Short queue of classified bytes between the front and the back.
module uvc_fifo import uvc_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  byte_class_t push_data_i,
  output logic        full_o,
  output logic        valid_o,
  output byte_class_t data_o,
  input  logic        pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  byte_class_t            mem_q [Depth];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/uvc_back.sv -----
// Back end: scheme match, escape tracking, byte count and verdict register.
module uvc_back import uvc_pkg::*; #(
  parameter int unsigned CountWidth = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] max_uri_bytes_i,
  input  logic        item_valid_i,
  input  byte_class_t item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        uri_ok_o,
  output logic [2:0]  fault_code_o
);

  localparam int unsigned CmpW = (CountWidth > 16) ? CountWidth : 16;

  logic [CountWidth-1:0] count_q, count_d;
  logic [2:0]            cand_q, cand_d;
  logic [2:0]            plen_q, plen_d;
  pct_phase_e            phase_q, phase_d;
  logic                  bad_q, bad_d;
  logic                  out_valid_q, out_valid_d;
  logic                  uri_ok_q;
  fault_e                fault_q, fault_d;
  logic                  slot_free, take_byte, take_term;
  logic [CountWidth-1:0] slen;
  logic                  matched;

  assign slot_free = ~out_valid_q | out_ready_i;
  assign take_byte = item_valid_i & ~item_i.term;
  assign take_term = item_valid_i & item_i.term & slot_free;
  assign pop_o     = take_byte | take_term;

  // verdict from the state left by the preceding bytes
  always_comb begin
    matched = 1'b1;
    slen    = '0;
    if (cand_q[0] && count_q >= CountWidth'(5)) begin
      slen = CountWidth'(5);
    end else if (cand_q[1] && count_q >= CountWidth'(6)) begin
      slen = CountWidth'(6);
    end else if (cand_q[2] && count_q >= CountWidth'(4)) begin
      slen = CountWidth'(4);
    end else begin
      matched = 1'b0;
    end

    priority if (!matched) begin
      fault_d = FAULT_SCHEME;
    end else if (count_q == slen) begin
      fault_d = FAULT_NO_DEST;
    end else if (CmpW'(count_q) > CmpW'(max_uri_bytes_i)) begin
      fault_d = FAULT_TOO_LONG;
    end else if (bad_q || phase_q != PCT_IDLE) begin
      fault_d = FAULT_NEEDS_PCT;
    end else begin
      fault_d = FAULT_OK;
    end
  end

  always_comb begin
    count_d     = count_q;
    cand_d      = cand_q;
    plen_d      = plen_q;
    phase_d     = phase_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (take_byte) begin
      if (plen_q < PrefixSat) begin
        for (int k = 0; k < 3; k++) begin
          if (plen_q < scheme_len(2'(k)) && item_i.low != scheme_char(2'(k), plen_q)) begin
            cand_d[k] = 1'b0;
          end
        end
        plen_d = plen_q + 3'd1;
      end

      unique case (phase_q)
        PCT_HEX1: begin
          if (item_i.hex) begin
            phase_d = PCT_HEX2;
          end else begin
            bad_d   = 1'b1;
            phase_d = PCT_IDLE;
          end
        end
        PCT_HEX2: begin
          if (!item_i.hex) begin
            bad_d = 1'b1;
          end
          phase_d = PCT_IDLE;
        end
        default: begin
          if (item_i.pct) begin
            phase_d = PCT_HEX1;
          end else if (!item_i.legal) begin
            bad_d = 1'b1;
          end
        end
      endcase

      // saturate
      if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
    end else if (take_term) begin
      out_valid_d = 1'b1;
      count_d     = '0;
      cand_d      = 3'b111;
      plen_d      = '0;
      phase_d     = PCT_IDLE;
      bad_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cand_q      <= 3'b111;
      plen_q      <= '0;
      phase_q     <= PCT_IDLE;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cand_q      <= cand_d;
      plen_q      <= plen_d;
      phase_q     <= phase_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_term) begin
      fault_q  <= fault_d;
      uri_ok_q <= (fault_d == FAULT_OK);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign uri_ok_o     = uri_ok_q;
  assign fault_code_o = fault_q;

endmodule

// ----- src/uri_scheme_and_char_validator.sv -----
// Top level of the URI scheme and character validator.
// Takes one URI byte per request, a zero byte ending the string, and gives one
// verdict (uri_ok_o, fault_code_o) per string: 0 ok, 1 bad scheme (http:, https:,
// ftp:, any case), 2 nothing after the scheme, 3 longer than max_uri_bytes,
// 4 a byte that needs percent encoding or a broken escape. The block sustains one
// byte per cycle while the queue has room; the front classifies each byte and
// pushes it into a FIFO_DEPTH entry queue; the back updates the match state and
// registers the verdict when it pops the terminator. The user must write the length
// limit through cfg_we_i/cfg_wdata_i (reset 2048) only while no string is in
// flight; the block does not enforce it. No clearing pass is needed after reset.
module uri_scheme_and_char_validator import uvc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef,
  parameter int unsigned FIFO_DEPTH  = FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  uri_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        uri_ok_o,
  output logic [2:0]  fault_code_o
);

  logic [15:0] max_uri_bytes_q;
  logic        push, queue_full, q_valid, pop;
  byte_class_t push_cls, q_cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_uri_bytes_q <= MaxUriReset;
    end else if (cfg_we_i) begin
      max_uri_bytes_q <= cfg_wdata_i;
    end
  end

  uvc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .uri_byte_i   (uri_byte_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cls_o        (push_cls)
  );

  uvc_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cls),
    .full_o      (queue_full),
    .valid_o     (q_valid),
    .data_o      (q_cls),
    .pop_i       (pop)
  );

  uvc_back #(
    .CountWidth (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_uri_bytes_i (max_uri_bytes_q),
    .item_valid_i    (q_valid),
    .item_i          (q_cls),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .uri_ok_o        (uri_ok_o),
    .fault_code_o    (fault_code_o)
  );

endmodule

// ----- src/uvc_checker.sv -----
// Port-level checks for the URI validator, bound to the top level.
module uvc_checker import uvc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       uri_ok_o,
  input logic [2:0] fault_code_o
);

  // hold a stalled verdict
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(uri_ok_o) &&
    $stable(fault_code_o))
    else $error("stalled verdict changed or dropped");

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (uri_ok_o == (fault_code_o == FAULT_OK)))
    else $error("uri_ok disagrees with fault_code");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fault_code_o == FAULT_OK || fault_code_o == FAULT_SCHEME ||
                     fault_code_o == FAULT_NO_DEST || fault_code_o == FAULT_TOO_LONG ||
                     fault_code_o == FAULT_NEEDS_PCT))
    else $error("fault_code out of range");

  a_no_verdict_from_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("verdict right after reset");

endmodule

bind uri_scheme_and_char_validator uvc_checker u_uvc_checker (.*);
